[rtl/iair_pkg.sv]
// ----------------------------------------------------------------------------
// iair_pkg: shared types and constants for the indexed array
// Command and status codes, beat field widths, the per-cell operation
// struct and the depth of the read-back reduction tree.
// ----------------------------------------------------------------------------
package iair_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int CMD_W     = 2;
  localparam int POS_W     = 6;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int ST_W      = 2;
  localparam int FAN       = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_WRITE  = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // broadcast to every cell; already qualified by the bounds checks
  typedef struct packed {
    logic ins;
    logic rem;
    logic wr;
    logic rd;
  } cell_op_t;

  // number of fan-in stages needed to bring depth words down to one
  function automatic int tree_levels(input int depth);
    int w;
    int n;
    w = depth;
    n = 0;
    while (w > 1) begin
      w = (w + FAN - 1) >> 2;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

[rtl/indexed_array_insert_remove.sv]
// ----------------------------------------------------------------------------
// indexed_array_insert_remove: bounded ordered array with insert/remove
// A row of cells, one per entry, shifts in parallel on insert and remove.
// ----------------------------------------------------------------------------
// One command is taken every cycle; busy is never raised. Each command
// returns one result beat on out_valid, registered first in the cell tap
// and then through each of the LEVELS stages of the fan-in-4 OR tree that
// gathers the addressed word from the cells. Results leave in command
// order and the receiver cannot stall them. Bounds and full checks use
// the fill level at acceptance, so back-to-back commands see each other's
// effects.
module indexed_array_insert_remove #(
  parameter int DEPTH = iair_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [iair_pkg::CMD_W-1:0]        in_command,
  input  logic [iair_pkg::POS_W-1:0]        in_position,
  input  logic signed [iair_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic signed [iair_pkg::DATA_W-1:0] out_data,
  output logic [iair_pkg::CNT_W-1:0]        out_count,
  output logic [iair_pkg::ST_W-1:0]         out_status
);

  localparam int FW     = $clog2(DEPTH + 1);
  localparam int AW     = (FW > iair_pkg::POS_W) ? FW : iair_pkg::POS_W;
  localparam int KW     = (FW > iair_pkg::CNT_W) ? FW : iair_pkg::CNT_W;
  localparam int LEVELS = iair_pkg::tree_levels(DEPTH);
  localparam int DW     = iair_pkg::DATA_W;

  logic                   fire;
  logic [FW-1:0]          fill_r;
  logic [FW-1:0]          fill_nxt;
  logic [AW-1:0]          pos_x;
  logic [AW-1:0]          fill_x;
  iair_pkg::cmd_t         cmd;
  iair_pkg::status_t      status;
  iair_pkg::cell_op_t     op;
  logic [KW-1:0]          fill_wide;

  logic [DW-1:0]          cell_data [DEPTH];
  logic [DW-1:0]          cell_tap  [DEPTH];
  logic [DW-1:0]          tree_word;

  logic [LEVELS:0]        vld_r;
  logic [iair_pkg::CNT_W-1:0] cnt_r [LEVELS+1];
  iair_pkg::status_t      st_r  [LEVELS+1];

  assign busy   = 1'b0;
  assign fire   = start && !busy;
  assign cmd    = iair_pkg::cmd_t'(in_command);
  assign pos_x  = AW'(in_position);
  assign fill_x = AW'(fill_r);

  always_comb begin
    status = iair_pkg::ST_OK;
    op     = '0;
    unique case (cmd)
      iair_pkg::CMD_INSERT: begin
        priority if (pos_x > fill_x) begin
          status = iair_pkg::ST_OOB;
        end else if (fill_r == FW'(DEPTH)) begin
          status = iair_pkg::ST_FULL;
        end else begin
          op.ins = fire;
        end
      end
      iair_pkg::CMD_REMOVE: begin
        if (pos_x >= fill_x) begin
          status = iair_pkg::ST_OOB;
        end else begin
          op.rem = fire;
          op.rd  = fire;
        end
      end
      iair_pkg::CMD_READ: begin
        if (pos_x >= fill_x) begin
          status = iair_pkg::ST_OOB;
        end else begin
          op.rd = fire;
        end
      end
      iair_pkg::CMD_WRITE: begin
        if (pos_x >= fill_x) begin
          status = iair_pkg::ST_OOB;
        end else begin
          op.wr = fire;
        end
      end
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    if (op.ins) begin
      fill_nxt = fill_r + FW'(1);
    end else if (op.rem) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DW-1:0] left;
    logic [DW-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    iair_cell #(
      .IDX (i),
      .AW  (AW)
    ) u_cell (
      .clk    (clk),
      .op     (op),
      .pos    (pos_x),
      .value  (in_value),
      .left   (left),
      .right  (right),
      .data_o (cell_data[i]),
      .tap_o  (cell_tap[i])
    );
  end

  iair_or_tree #(
    .DEPTH  (DEPTH),
    .LEVELS (LEVELS)
  ) u_tree (
    .clk    (clk),
    .taps   (cell_tap),
    .word_o (tree_word)
  );

  // result side-band travels alongside the tree
  assign fill_wide = KW'(fill_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LEVELS-1:0], fire};
    end
  end

  always_ff @(posedge clk) begin
    cnt_r[0] <= fill_wide[iair_pkg::CNT_W-1:0];
    st_r[0]  <= status;
    for (int s = 1; s <= LEVELS; s++) begin
      cnt_r[s] <= cnt_r[s-1];
      st_r[s]  <= st_r[s-1];
    end
  end

  assign out_valid  = vld_r[LEVELS];
  assign out_data   = tree_word;
  assign out_count  = cnt_r[LEVELS];
  assign out_status = st_r[LEVELS];

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill level beyond capacity");

  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    op.ins |=> fill_r == $past(fill_r) + FW'(1))
    else $error("insert did not grow fill");

  a_err_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && status != iair_pkg::ST_OK) |=> fill_r == $past(fill_r))
    else $error("rejected command changed fill");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != iair_pkg::ST_OK) |-> out_data == '0)
    else $error("rejected command returned data");

endmodule

[rtl/iair_cell.sv]
// ----------------------------------------------------------------------------
// iair_cell: one storage slot of the array
// Holds one word; takes the left neighbour on insert above the position,
// the right neighbour on remove at or above it, and the beat value at the
// position. Presents its old word on a tap register for read and remove.
// ----------------------------------------------------------------------------
module iair_cell #(
  parameter int IDX = 0,
  parameter int AW  = 6
) (
  input  logic                            clk,
  input  iair_pkg::cell_op_t              op,
  input  logic [AW-1:0]                   pos,
  input  logic [iair_pkg::DATA_W-1:0]     value,
  input  logic [iair_pkg::DATA_W-1:0]     left,
  input  logic [iair_pkg::DATA_W-1:0]     right,
  output logic [iair_pkg::DATA_W-1:0]     data_o,
  output logic [iair_pkg::DATA_W-1:0]     tap_o
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [iair_pkg::DATA_W-1:0] data_r;
  logic [iair_pkg::DATA_W-1:0] tap_r;
  logic                        hit;
  logic                        above;

  assign hit   = (MY_IDX == pos);
  assign above = (MY_IDX > pos);

  always_ff @(posedge clk) begin
    priority if ((op.ins || op.wr) && hit) begin
      data_r <= value;
    end else if (op.ins && above) begin
      data_r <= left;
    end else if (op.rem && (above || hit)) begin
      data_r <= right;
    end
  end

  always_ff @(posedge clk) begin
    tap_r <= (op.rd && hit) ? data_r : '0;
  end

  assign data_o = data_r;
  assign tap_o  = tap_r;

endmodule

[rtl/iair_or_tree.sv]
// ----------------------------------------------------------------------------
// iair_or_tree: registered OR reduction of the cell taps
// At most one tap is non-zero; each stage ORs groups of FAN words and
// registers the result, LEVELS stages in all.
// ----------------------------------------------------------------------------
module iair_or_tree #(
  parameter int DEPTH  = iair_pkg::DEPTH_DEF,
  parameter int LEVELS = 3
) (
  input  logic                        clk,
  input  logic [iair_pkg::DATA_W-1:0] taps [DEPTH],
  output logic [iair_pkg::DATA_W-1:0] word_o
);

  localparam int FAN = iair_pkg::FAN;

  logic [iair_pkg::DATA_W-1:0] lvl_r [LEVELS][DEPTH];

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    for (genvar j = 0; j < DEPTH; j++) begin : g_node
      logic [FAN-1:0][iair_pkg::DATA_W-1:0] kids;
      for (genvar c = 0; c < FAN; c++) begin : g_kid
        if (FAN * j + c < DEPTH) begin : g_in
          if (k == 0) begin : g_leaf
            assign kids[c] = taps[FAN*j+c];
          end else begin : g_inner
            assign kids[c] = lvl_r[k-1][FAN*j+c];
          end
        end else begin : g_pad
          assign kids[c] = '0;
        end
      end
      always_ff @(posedge clk) begin
        lvl_r[k][j] <= kids[0] | kids[1] | kids[2] | kids[3];
      end
    end
  end

  assign word_o = lvl_r[LEVELS-1][0];

endmodule
